// ===== hdl/miller_rabin_witness_test_defines.svh =====
// assertion macros used by the checker file of the miller-rabin witness block
// no dependencies
`ifndef MILLER_RABIN_WITNESS_TEST_DEFINES_SVH
`define MILLER_RABIN_WITNESS_TEST_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MRW_ASSERT_NOW(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define MRW_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mrw_pkg.sv =====
// shared constants for the miller-rabin witness block
// no dependencies
`default_nettype none

package mrw_pkg;

  localparam int CAND_BITS     = 64;
  localparam int WORD_BITS_DEF = 64;

endpackage

`default_nettype wire

// ===== hdl/mrw_ifs.sv =====
// valid/ready channel interfaces for input and result transactions
// depends on mrw_pkg
`default_nettype none

interface mrw_in_if
  import mrw_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CAND_BITS-1:0] candidate;
  logic [CAND_BITS-1:0] witness;

  modport source (output valid, output candidate, output witness, input ready);
  modport sink   (input valid, input candidate, input witness, output ready);
endinterface

interface mrw_out_if;
  logic valid;
  logic ready;
  logic probable_prime;
  logic invalid_candidate;

  modport source (output valid, output probable_prime, output invalid_candidate,
                  input ready);
  modport sink   (input valid, input probable_prime, input invalid_candidate,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/mrw_mulmod.sv =====
// bit-serial shift-and-add modular multiplier, one operand bit per cycle
// depends on mrw_pkg
`default_nettype none

module mrw_mulmod
  import mrw_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [WORD_BITS-1:0] x,
  input  wire logic [WORD_BITS-1:0] y,
  input  wire logic [WORD_BITS-1:0] n,
  output logic                      done,
  output logic [WORD_BITS-1:0]      result
);

  localparam int CW = $clog2(WORD_BITS);

  logic                 run_r, run_nxt;
  logic                 done_r, done_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [WORD_BITS-1:0] acc_r, acc_nxt;
  logic [WORD_BITS-1:0] xx_r, xx_nxt;
  logic [WORD_BITS-1:0] y_r, y_nxt;

  function automatic logic [WORD_BITS-1:0] add_mod(input logic [WORD_BITS-1:0] a,
                                                   input logic [WORD_BITS-1:0] b,
                                                   input logic [WORD_BITS-1:0] m);
    logic [WORD_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[WORD_BITS-1:0];
  endfunction

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    xx_nxt   = xx_r;
    y_nxt    = y_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      acc_nxt = '0;
      xx_nxt  = x;
      y_nxt   = y;
    end else if (run_r) begin
      if (y_r[0]) begin
        acc_nxt = add_mod(acc_r, xx_r, n);
      end
      xx_nxt  = add_mod(xx_r, xx_r, n);
      y_nxt   = y_r >> 1;
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(WORD_BITS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    xx_r  <= xx_nxt;
    y_r   <= y_nxt;
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

`default_nettype wire

// ===== hdl/miller_rabin_witness_test.sv =====
// sequence from accept to out_ch.valid: a candidate below 3 goes straight to the output
// state; else a witness reduction, an odd-part split, per exponent bit an issue state and
// one or two products, a check state, up to s-1 squarings and an output state that waits
// for a stalled result
// throughput: one transaction at a time, in_ch.ready is high only while idle
// reset: synchronous active-low rst_n clears the sequencer and output valid
`default_nettype none

module miller_rabin_witness_test
  import mrw_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mrw_in_if.sink    in_ch,
  mrw_out_if.source out_ch
);

  localparam int CW = $clog2(WORD_BITS);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RED   = 9'b000000010,
    S_SPLIT = 9'b000000100,
    S_PBIT  = 9'b000001000,
    S_PR    = 9'b000010000,
    S_PB    = 9'b000100000,
    S_CHK   = 9'b001000000,
    S_SQ    = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t               state_r, state_nxt;
  logic [WORD_BITS-1:0] n_r, n_nxt;
  logic [WORD_BITS-1:0] nm1_r, nm1_nxt;
  logic [WORD_BITS-1:0] a_r, a_nxt;
  logic [WORD_BITS-1:0] rem_r, rem_nxt;
  logic [WORD_BITS-1:0] d_r, d_nxt;
  logic [WORD_BITS-1:0] e_r, e_nxt;
  logic [WORD_BITS-1:0] x_r, x_nxt;
  logic [WORD_BITS-1:0] base_r, base_nxt;
  logic [CW-1:0]        s_r, s_nxt;
  logic [CW-1:0]        j_r, j_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 pass_r, pass_nxt;
  logic                 inv_r, inv_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_prime_r, out_prime_nxt;
  logic                 out_inv_r, out_inv_nxt;

  logic                 mul_start;
  logic [WORD_BITS-1:0] mul_x;
  logic [WORD_BITS-1:0] mul_y;
  logic                 mul_done;
  logic [WORD_BITS-1:0] mul_res;

  logic [WORD_BITS-1:0] n_in;
  logic [WORD_BITS:0]   red_t;
  logic [WORD_BITS:0]   red_v;

  mrw_mulmod #(
    .WORD_BITS(WORD_BITS)
  ) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .x      (mul_x),
    .y      (mul_y),
    .n      (n_r),
    .done   (mul_done),
    .result (mul_res)
  );

  assign n_in  = in_ch.candidate[WORD_BITS-1:0];
  assign red_t = {rem_r, a_r[WORD_BITS-1]};
  assign red_v = (red_t >= {1'b0, n_r}) ? (red_t - {1'b0, n_r}) : red_t;

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    nm1_nxt       = nm1_r;
    a_nxt         = a_r;
    rem_nxt       = rem_r;
    d_nxt         = d_r;
    e_nxt         = e_r;
    x_nxt         = x_r;
    base_nxt      = base_r;
    s_nxt         = s_r;
    j_nxt         = j_r;
    cnt_nxt       = cnt_r;
    pass_nxt      = pass_r;
    inv_nxt       = inv_r;
    out_valid_nxt = out_valid_r;
    out_prime_nxt = out_prime_r;
    out_inv_nxt   = out_inv_r;
    mul_start     = 1'b0;
    mul_x         = x_r;
    mul_y         = base_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          n_nxt   = n_in;
          nm1_nxt = n_in - WORD_BITS'(1);
          a_nxt   = in_ch.witness[WORD_BITS-1:0];
          rem_nxt = '0;
          cnt_nxt = '0;
          if (n_in < WORD_BITS'(3)) begin
            pass_nxt  = 1'b0;
            inv_nxt   = 1'b1;
            state_nxt = S_DONE;
          end else begin
            inv_nxt   = 1'b0;
            state_nxt = S_RED;
          end
        end
      end
      S_RED: begin
        rem_nxt = red_v[WORD_BITS-1:0];
        a_nxt   = a_r << 1;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(WORD_BITS - 1)) begin
          d_nxt     = nm1_r;
          s_nxt     = '0;
          state_nxt = S_SPLIT;
        end
      end
      S_SPLIT: begin
        if (d_r[0]) begin
          e_nxt     = d_r;
          x_nxt     = WORD_BITS'(1);
          base_nxt  = rem_r;
          cnt_nxt   = '0;
          state_nxt = S_PBIT;
        end else begin
          d_nxt = d_r >> 1;
          s_nxt = s_r + CW'(1);
        end
      end
      S_PBIT: begin
        mul_start = 1'b1;
        if (e_r[0]) begin
          mul_x     = x_r;
          mul_y     = base_r;
          state_nxt = S_PR;
        end else begin
          mul_x     = base_r;
          mul_y     = base_r;
          state_nxt = S_PB;
        end
      end
      S_PR: begin
        if (mul_done) begin
          x_nxt     = mul_res;
          mul_start = 1'b1;
          mul_x     = base_r;
          mul_y     = base_r;
          state_nxt = S_PB;
        end
      end
      S_PB: begin
        if (mul_done) begin
          base_nxt = mul_res;
          e_nxt    = e_r >> 1;
          cnt_nxt  = cnt_r + CW'(1);
          if (cnt_r == CW'(WORD_BITS - 1)) begin
            state_nxt = S_CHK;
          end else begin
            state_nxt = S_PBIT;
          end
        end
      end
      S_CHK: begin
        if (x_r == WORD_BITS'(1) || x_r == nm1_r) begin
          pass_nxt  = 1'b1;
          state_nxt = S_DONE;
        end else if (s_r <= CW'(1)) begin
          pass_nxt  = 1'b0;
          state_nxt = S_DONE;
        end else begin
          j_nxt     = CW'(1);
          mul_start = 1'b1;
          mul_x     = x_r;
          mul_y     = x_r;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        if (mul_done) begin
          x_nxt = mul_res;
          if (mul_res == WORD_BITS'(1)) begin
            pass_nxt  = 1'b0;
            state_nxt = S_DONE;
          end else if (mul_res == nm1_r) begin
            pass_nxt  = 1'b1;
            state_nxt = S_DONE;
          end else if (j_r + CW'(1) == s_r) begin
            pass_nxt  = 1'b0;
            state_nxt = S_DONE;
          end else begin
            j_nxt     = j_r + CW'(1);
            mul_start = 1'b1;
            mul_x     = mul_res;
            mul_y     = mul_res;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = pass_r;
          out_inv_nxt   = inv_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      s_r         <= '0;
      j_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      s_r         <= s_nxt;
      j_r         <= j_nxt;
    end
    n_r         <= n_nxt;
    nm1_r       <= nm1_nxt;
    a_r         <= a_nxt;
    rem_r       <= rem_nxt;
    d_r         <= d_nxt;
    e_r         <= e_nxt;
    x_r         <= x_nxt;
    base_r      <= base_nxt;
    pass_r      <= pass_nxt;
    inv_r       <= inv_nxt;
    out_prime_r <= out_prime_nxt;
    out_inv_r   <= out_inv_nxt;
  end

  assign in_ch.ready              = (state_r == S_IDLE);
  assign out_ch.valid             = out_valid_r;
  assign out_ch.probable_prime    = out_prime_r;
  assign out_ch.invalid_candidate = out_inv_r;

endmodule

`default_nettype wire

// ===== hdl/mrw_checker.sv =====
// port-level checker for the miller-rabin witness block, bound to the top level
// depends on miller_rabin_witness_test_defines.svh and miller_rabin_witness_test
`default_nettype none

`include "miller_rabin_witness_test_defines.svh"

module mrw_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_probable_prime,
  input wire logic out_invalid_candidate
);

  `MRW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `MRW_ASSERT_NOW(a_inv_fail, clk, rst_n, out_valid && out_invalid_candidate, !out_probable_prime, "invalid candidate reported as pass")
  `MRW_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready, "new transaction taken while busy")
  `MRW_ASSERT_NEXT(a_no_early, clk, rst_n, in_valid && in_ready, !$rose(out_valid), "result raised one cycle after accept")

endmodule

bind miller_rabin_witness_test mrw_checker u_mrw_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_ch.valid),
  .in_ready              (in_ch.ready),
  .out_valid             (out_ch.valid),
  .out_ready             (out_ch.ready),
  .out_probable_prime    (out_ch.probable_prime),
  .out_invalid_candidate (out_ch.invalid_candidate)
);

`default_nettype wire
